/* hw/rtl/bw_pkg.sv */
package bw_pkg;

	// Width of each saturated weight on the output.
	localparam int OUT_W = 32;

	// A dot product of two three-lane vectors grows by this many bits over one product.
	localparam int DOT_GROW = 2;

	// Register stages in the vector front end and in the split multiplier.
	localparam int PREP_STAGES = 3;
	localparam int MUL_STAGES = 2;

	localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

/* hw/rtl/bw_prep.sv */
module bw_prep import bw_pkg::*; #(
	parameter int COORD_BITS = 16,
	localparam int E_W = COORD_BITS + 1,
	localparam int P_W = 2 * E_W,
	localparam int DOT_W = P_W + DOT_GROW
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [12*COORD_BITS-1:0]      crd,
	output logic signed [DOT_W-1:0]       dot [5]
);

	logic signed [COORD_BITS-1:0] c [12];
	logic signed [E_W-1:0] e_s1 [9];
	logic signed [P_W-1:0] p_s2 [15];
	logic signed [DOT_W-1:0] d_s3 [5];

	always_comb begin
		for (int i = 0; i < 12; i++) begin
			c[i] = crd[i*COORD_BITS +: COORD_BITS];
		end
	end

	// Edge vectors B-A, C-A and P-A, three lanes each.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				e_s1[k]     <= E_W'(c[3+k]) - E_W'(c[k]);
				e_s1[3 + k] <= E_W'(c[6+k]) - E_W'(c[k]);
				e_s1[6 + k] <= E_W'(c[9+k]) - E_W'(c[k]);
			end
		end
	end

	// Products in the order d00, d01, d11, d20, d21, three lanes each.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				p_s2[k]      <= e_s1[k] * e_s1[k];
				p_s2[3 + k]  <= e_s1[k] * e_s1[3+k];
				p_s2[6 + k]  <= e_s1[3+k] * e_s1[3+k];
				p_s2[9 + k]  <= e_s1[6+k] * e_s1[k];
				p_s2[12 + k] <= e_s1[6+k] * e_s1[3+k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 5; j++) begin
				d_s3[j] <= DOT_W'(p_s2[3*j]) + DOT_W'(p_s2[3*j+1]) + DOT_W'(p_s2[3*j+2]);
			end
		end
	end

	assign dot = d_s3;

endmodule

/* hw/rtl/bw_mul.sv */
module bw_mul import bw_pkg::*; #(
	parameter int A_W = 38,
	localparam int LO_W = A_W / 2,
	localparam int HI_W = A_W - LO_W
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [A_W-1:0]   a,
	input  logic signed [A_W-1:0]   b,
	output logic signed [2*A_W-1:0] p
);

	logic signed [A_W+LO_W:0]   pl_s1;
	logic signed [A_W+HI_W-1:0] ph_s1;
	logic signed [2*A_W-1:0]    p_s2;
	logic signed [2*A_W-1:0]    pl_x;
	logic signed [2*A_W-1:0]    ph_x;

	// The low half of b is taken as unsigned, the high half carries the sign.
	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1 <= a * $signed({1'b0, b[LO_W-1:0]});
			ph_s1 <= a * $signed(b[A_W-1:LO_W]);
		end
	end

	assign pl_x = (2*A_W)'(pl_s1);
	assign ph_x = (2*A_W)'(ph_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= (ph_x <<< LO_W) + pl_x;
		end
	end

	assign p = p_s2;

endmodule

/* hw/rtl/bw_div.sv */
module bw_div import bw_pkg::*; #(
	parameter int W = 77,
	parameter int FRAC = 16,
	localparam int NW = W + FRAC,
	localparam int QW = NW + 2
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [W-1:0]   num,
	input  logic signed [W-1:0]   den,
	output logic signed [QW-1:0]  quo
);

	// Each stage shifts one numerator bit into the remainder and one
	// quotient bit into the low end of the same word.
	logic [W-1:0]  rem_s [NW+1];
	logic [NW-1:0] nq_s  [NW+1];
	logic [W-1:0]  den_s [NW+1];
	logic          neg_s [NW+1];
	logic [W:0]    trial [NW+1];
	logic [W:0]    diff  [NW+1];
	logic          ge    [NW+1];
	logic [W-1:0]  num_mag;
	logic [W-1:0]  den_mag;
	logic [NW:0]   q_rnd;
	logic          rnd;
	logic signed [QW-1:0] res_s;

	assign num_mag = num[W-1] ? W'(-num) : W'(num);
	assign den_mag = den[W-1] ? W'(-den) : W'(den);

	always_comb begin
		trial[0] = '0;
		diff[0]  = '0;
		ge[0]    = 1'b0;
		for (int k = 1; k <= NW; k++) begin
			trial[k] = {rem_s[k-1], nq_s[k-1][NW-1]};
			diff[k]  = trial[k] - {1'b0, den_s[k-1]};
			ge[k]    = trial[k] >= {1'b0, den_s[k-1]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= '0;
			nq_s[0]  <= {num_mag, {FRAC{1'b0}}};
			den_s[0] <= den_mag;
			neg_s[0] <= num[W-1] ^ den[W-1];
			for (int k = 1; k <= NW; k++) begin
				rem_s[k] <= ge[k] ? diff[k][W-1:0] : trial[k][W-1:0];
				nq_s[k]  <= {nq_s[k-1][NW-2:0], ge[k]};
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	// Round half away from zero on the magnitude, then restore the sign.
	assign rnd   = {rem_s[NW], 1'b0} >= {1'b0, den_s[NW]};
	assign q_rnd = {1'b0, nq_s[NW]} + (NW+1)'(rnd);

	always_ff @(posedge clk) begin
		if (en) begin
			res_s <= neg_s[NW] ? -$signed({1'b0, q_rnd}) : $signed({1'b0, q_rnd});
		end
	end

	assign quo = res_s;

endmodule

/* hw/rtl/barycentric_weights.sv */
// Barycentric weights of a point P against a triangle A, B, C in 3D. Each input item
// packs ax, ay, az, bx, by_coord, bz, cx, cy, cz, px, py, pz (signed Q8.8 at the
// default width) and gives one result item: weight_u (of B), weight_v (of C) and
// weight_w = 1 - u - v, each signed Q16.16 rounded half away from zero and saturated
// to 32 bits, with tuser set when the corners are collinear and the weights are zero.
// The block takes one item every clock while the output is not stalled. Its
// bit-per-stage restoring divider follows three front-end stages, two multiplier
// stages and the determinant stage. A stall on the output side holds the whole
// pipeline.
module barycentric_weights import bw_pkg::*; #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS_OUT = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// ax, ay, az, bx, by_coord, bz, cx, cy, cz, px, py, pz from the lowest bit up
	input  logic [((12*COORD_BITS+7)/8)*8-1:0]   s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// weight_u, weight_v, weight_w from the lowest bit up
	output logic [3*OUT_W-1:0]                   m_tdata,
	// degenerate
	output logic                                 m_tuser
);

	localparam int DOT_W = 2 * (COORD_BITS + 1) + DOT_GROW;
	localparam int DEN_W = 2 * DOT_W + 1;
	localparam int NW = DEN_W + FRAC_BITS_OUT;
	localparam int QW = NW + 2;
	localparam int WW = QW + 2;
	localparam int DIV_LAT = NW + 2;
	localparam int LAT = PREP_STAGES + MUL_STAGES + 1 + DIV_LAT + 1;
	localparam logic signed [WW-1:0] ONE_W = WW'(1) <<< FRAC_BITS_OUT;

	logic en;
	logic vld_q [LAT];
	logic deg_q [DIV_LAT];
	logic signed [DOT_W-1:0] dot [5];
	logic signed [2*DOT_W-1:0] pr [6];
	logic signed [DEN_W-1:0] den_s6;
	logic signed [DEN_W-1:0] nu_s6;
	logic signed [DEN_W-1:0] nv_s6;
	logic deg_s6;
	logic signed [QW-1:0] qu;
	logic signed [QW-1:0] qv;
	logic signed [WW-1:0] w_full;
	logic [3*OUT_W-1:0] out_data_q;
	logic out_deg_q;

	function automatic logic [OUT_W-1:0] sat_w(input logic signed [WW-1:0] x);
		if (x[WW-1:OUT_W-1] == '0 || x[WW-1:OUT_W-1] == {(WW-OUT_W+1){1'b1}}) begin
			return x[OUT_W-1:0];
		end
		return x[WW-1] ? SAT_MIN : SAT_MAX;
	endfunction

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= s_tvalid;
			for (int i = 1; i < LAT; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	bw_prep #(.COORD_BITS(COORD_BITS)) u_prep (
		.clk (clk),
		.en  (en),
		.crd (s_tdata[12*COORD_BITS-1:0]),
		.dot (dot)
	);

	// Operand order: d00*d11, d01*d01, d11*d20, d01*d21, d00*d21, d01*d20.
	bw_mul #(.A_W(DOT_W)) u_mul0 (.clk(clk), .en(en), .a(dot[0]), .b(dot[2]), .p(pr[0]));
	bw_mul #(.A_W(DOT_W)) u_mul1 (.clk(clk), .en(en), .a(dot[1]), .b(dot[1]), .p(pr[1]));
	bw_mul #(.A_W(DOT_W)) u_mul2 (.clk(clk), .en(en), .a(dot[2]), .b(dot[3]), .p(pr[2]));
	bw_mul #(.A_W(DOT_W)) u_mul3 (.clk(clk), .en(en), .a(dot[1]), .b(dot[4]), .p(pr[3]));
	bw_mul #(.A_W(DOT_W)) u_mul4 (.clk(clk), .en(en), .a(dot[0]), .b(dot[4]), .p(pr[4]));
	bw_mul #(.A_W(DOT_W)) u_mul5 (.clk(clk), .en(en), .a(dot[1]), .b(dot[3]), .p(pr[5]));

	always_ff @(posedge clk) begin
		if (en) begin
			den_s6 <= DEN_W'(pr[0]) - DEN_W'(pr[1]);
			nu_s6  <= DEN_W'(pr[2]) - DEN_W'(pr[3]);
			nv_s6  <= DEN_W'(pr[4]) - DEN_W'(pr[5]);
			deg_s6 <= pr[0] == pr[1];
		end
	end

	// A zero determinant still runs through the dividers; its quotient is dropped.
	bw_div #(.W(DEN_W), .FRAC(FRAC_BITS_OUT)) u_div_u (
		.clk (clk),
		.en  (en),
		.num (nu_s6),
		.den (den_s6),
		.quo (qu)
	);

	bw_div #(.W(DEN_W), .FRAC(FRAC_BITS_OUT)) u_div_v (
		.clk (clk),
		.en  (en),
		.num (nv_s6),
		.den (den_s6),
		.quo (qv)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			deg_q[0] <= deg_s6;
			for (int i = 1; i < DIV_LAT; i++) begin
				deg_q[i] <= deg_q[i-1];
			end
		end
	end

	assign w_full = ONE_W - WW'(qu) - WW'(qv);

	always_ff @(posedge clk) begin
		if (en) begin
			out_deg_q <= deg_q[DIV_LAT-1];
			if (deg_q[DIV_LAT-1]) begin
				out_data_q <= '0;
			end else begin
				out_data_q <= {sat_w(w_full), sat_w(WW'(qv)), sat_w(WW'(qu))};
			end
		end
	end

	assign m_tvalid = vld_q[LAT-1];
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_deg_q;

endmodule
